/* src/fc_pkg.sv */
// Shared types, constants and factorial helpers for the factoradic converter.
package fc_pkg;

  // Result field widths and the highest factorial position within 32 bits.
  localparam int unsigned DigitW = 4;
  localparam int unsigned PosW   = 4;
  localparam int unsigned MaxPos = 12;

  // What one cell reports to the collector: token present and its digit.
  typedef struct packed {
    logic              valid;
    logic [DigitW-1:0] digit;
  } fc_tap_t;

  // k! as a 64-bit constant.
  function automatic logic [63:0] fact(input int unsigned k);
    logic [63:0] acc;
    acc = 64'd1;
    for (int unsigned i = 2; i <= k; i++) begin
      acc = acc * 64'(i);
    end
    return acc;
  endfunction

  // Highest position k whose k! fits in a value of the given width.
  function automatic int unsigned num_positions(input int unsigned w);
    int unsigned n;
    n = 1;
    for (int unsigned k = 2; k <= MaxPos; k++) begin
      if (fact(k) < (64'd1 << w)) begin
        n = k;
      end
    end
    return n;
  endfunction

endpackage

/* src/factoradic_converter.sv */
// Top level of the factoradic converter: digit cell chain and output register.
//
//   Channel   Direction  Handshake                Payload
//   input     in         in_valid_i / in_stall_o  value_i
//   output    out        out_valid_o / out_stall_i digit_o, position_o, last_o
//
// A request is loaded straight into the cell of its leading position k and
// then moves down one cell per cycle while the output is not stalled, so it
// yields k digits (k from 1 to 12), each then held in the output register.
// A new request is taken once the previous one has left the chain.
// Reset clears the cell tokens and the output valid; data registers are not
// reset. A stalled output freezes the whole chain.
module factoradic_converter import fc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DigitW-1:0] digit_o,
  output logic [PosW-1:0]   position_o,
  output logic              last_o
);

  localparam int unsigned NumPos = num_positions(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] value;
  logic [PosW-1:0]        top_pos;
  logic                   busy;
  logic                   accept;
  logic                   adv;

  logic                   valid_chain [1:NumPos+1];
  logic [VALUE_WIDTH-1:0] rem_chain   [1:NumPos+1];
  fc_tap_t                taps        [1:NumPos];

  logic [DigitW-1:0] sel_digit;
  logic [PosW-1:0]   sel_pos;

  logic              out_valid_d, out_valid_q;
  logic [DigitW-1:0] digit_d, digit_q;
  logic [PosW-1:0]   pos_d, pos_q;
  logic              last_d, last_q;

  // Only the low bits of the request are converted.
  assign value = value_i[VALUE_WIDTH-1:0];

  // Leading position: highest k whose k! does not exceed the value.
  always_comb begin
    top_pos = PosW'(1);
    for (int unsigned k = 2; k <= NumPos; k++) begin
      if ({{(64-VALUE_WIDTH){1'b0}}, value} >= fact(k)) begin
        top_pos = PosW'(k);
      end
    end
  end

  // Chain occupancy and handshakes.
  always_comb begin
    busy = 1'b0;
    for (int unsigned k = 1; k <= NumPos; k++) begin
      busy = busy | taps[k].valid;
    end
  end

  assign in_stall_o = busy;
  assign accept     = in_valid_i & ~busy;
  assign adv        = ~out_valid_q | ~out_stall_i;

  // Nothing enters the chain above the top cell.
  assign valid_chain[NumPos+1] = 1'b0;
  assign rem_chain[NumPos+1]   = '0;

  for (genvar k = 1; k <= NumPos; k++) begin : g_cell
    fc_cell #(
      .K(k),
      .W(VALUE_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .load_i     (accept && (top_pos == PosW'(k))),
      .load_rem_i (value),
      .up_valid_i (valid_chain[k+1]),
      .up_rem_i   (rem_chain[k+1]),
      .tap_o      (taps[k]),
      .valid_o    (valid_chain[k]),
      .rem_o      (rem_chain[k])
    );
  end

  // At most one cell holds the token, so the taps are simply merged.
  always_comb begin
    sel_digit = '0;
    sel_pos   = '0;
    for (int unsigned k = 1; k <= NumPos; k++) begin
      if (taps[k].valid) begin
        sel_digit = sel_digit | taps[k].digit;
        sel_pos   = sel_pos | PosW'(k);
      end
    end
  end

  // Output register: takes the current digit whenever it is free or drained.
  always_comb begin
    out_valid_d = out_valid_q;
    digit_d     = digit_q;
    pos_d       = pos_q;
    last_d      = last_q;
    if (adv) begin
      out_valid_d = busy;
      digit_d     = sel_digit;
      pos_d       = sel_pos;
      last_d      = (sel_pos == PosW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    pos_q   <= pos_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign digit_o     = digit_q;
  assign position_o  = pos_q;
  assign last_o      = last_q;

endmodule

/* src/fc_cell.sv */
// One digit cell of the converter chain, fixed to factorial position K.
module fc_cell import fc_pkg::*; #(
  parameter int unsigned K = 1,
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         adv_i,
  input  logic         load_i,
  input  logic [W-1:0] load_rem_i,
  input  logic         up_valid_i,
  input  logic [W-1:0] up_rem_i,
  output fc_tap_t      tap_o,
  output logic         valid_o,
  output logic [W-1:0] rem_o
);

  localparam logic [63:0] FactK = fact(K);

  logic         valid_d, valid_q;
  logic [W-1:0] rem_d, rem_q;
  logic [DigitW-1:0] digit;
  logic [W-1:0] sub;

  // The request token either arrives from the cell above, is loaded
  // directly from the input, or waits here while the output is stalled.
  always_comb begin
    valid_d = load_i | (adv_i ? up_valid_i : valid_q);
    if (load_i) begin
      rem_d = load_rem_i;
    end else if (adv_i) begin
      rem_d = up_rem_i;
    end else begin
      rem_d = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  // Parallel compares against the multiples of K!; the largest one met
  // gives the digit and the amount to subtract.
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int unsigned d = 1; d <= K; d++) begin
      if ({{(64-W){1'b0}}, rem_q} >= FactK * 64'(d)) begin
        digit = DigitW'(d);
        sub   = W'(FactK * 64'(d));
      end
    end
  end

  assign rem_o       = rem_q - sub;
  assign valid_o     = valid_q;
  assign tap_o.valid = valid_q;
  assign tap_o.digit = digit;

endmodule
